@@ src/aes128_ccm_engine_unit_assert.svh @@
// assertion helpers used by the ccm_core module
// they expect a clock named clk and an active-low reset named rst_n in scope
`ifndef AES128_CCM_ENGINE_UNIT_ASSERT_SVH
`define AES128_CCM_ENGINE_UNIT_ASSERT_SVH

// condition holds at every edge outside reset
`define CCM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/ccm_pkg.sv @@
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types, codes and AES helper functions for the CCM engine.
// ----------------------------------------------------------------------------
package ccm_pkg;

  localparam logic [2:0] REG_KEY_HIGH   = 3'd0;
  localparam logic [2:0] REG_KEY_LOW    = 3'd1;
  localparam logic [2:0] REG_NONCE_HIGH = 3'd2;
  localparam logic [2:0] REG_NONCE_LOW  = 3'd3;
  localparam logic [2:0] REG_AAD_LEN    = 3'd4;
  localparam logic [2:0] REG_PAY_LEN    = 3'd5;
  localparam logic [2:0] REG_DIRECTION  = 3'd6;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_TAG     = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [7:0] FLAGS_B0  = 8'h59;
  localparam logic [7:0] FLAGS_CTR = 8'h01;
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [15:0] LONG_AAD = 16'hFF00;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       auth_ok;
    logic       last;
  } res_t;

  typedef struct packed {
    logic         start;
    logic [127:0] blk;
    logic [127:0] key;
  } aes_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] data;
  } aes_rsp_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  // byte 0 of a block sits in the top bits
  function automatic logic [7:0] get_byte(input logic [127:0] v, input logic [3:0] off);
    logic [7:0] b;
    b = '0;
    for (int i = 0; i < 16; i++) begin
      if (off == 4'(i)) b = v[127-8*i -: 8];
    end
    return b;
  endfunction

  function automatic logic [127:0] set_byte(input logic [127:0] v, input logic [3:0] off,
                                            input logic [7:0] b);
    logic [127:0] r;
    r = v;
    for (int i = 0; i < 16; i++) begin
      if (off == 4'(i)) r[127-8*i -: 8] = b;
    end
    return r;
  endfunction

  // next round key from the current one
  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // subbytes, shiftrows and, except in the final round, mixcolumns
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic fin);
    logic [7:0] s [16];
    logic [7:0] h [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) h[4*c+i] = SBOX[s[4*((c+i)%4)+i]];
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = h[4*c]; a1 = h[4*c+1]; a2 = h[4*c+2]; a3 = h[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        h[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        h[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        h[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        h[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = h[i];
    return r;
  endfunction

endpackage

@@ src/ccm_fifo.sv @@
// ----------------------------------------------------------------------------
// ccm_fifo
// Small register queue that decouples the two sides of the engine.
// ----------------------------------------------------------------------------
module ccm_fifo #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  input  logic [W-1:0] wr_data,
  output logic         wr_full,
  output logic         rd_valid,
  output logic [W-1:0] rd_data,
  input  logic         rd_pop
);
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  mem_r [D];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign wr_full  = (cnt_r == CW'(D));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_full;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(D - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(D - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end
endmodule

@@ src/ccm_aes.sv @@
// ----------------------------------------------------------------------------
// ccm_aes
// Iterative AES-128 encryption, one round per cycle, keys expanded on the fly.
// ----------------------------------------------------------------------------
module ccm_aes (
  input  logic              clk,
  input  logic              rst_n,
  input  ccm_pkg::aes_req_t req,
  output ccm_pkg::aes_rsp_t rsp
);
  import ccm_pkg::*;

  logic [127:0] st_r, rk_r, rk_n;
  logic [7:0]   rc_r;
  logic [3:0]   cnt_r;
  logic         busy_r, done_r;

  assign rk_n = key_step(rk_r, rc_r);
  assign rsp  = '{busy: busy_r, done: done_r, data: st_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        st_r   <= req.blk ^ req.key;
        rk_r   <= req.key;
        rc_r   <= RCON_INIT;
        cnt_r  <= 4'd1;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rk_r  <= rk_n;
        st_r  <= aes_round(st_r, cnt_r == 4'd10) ^ rk_n;
        rc_r  <= xtime(rc_r);
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd10) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

@@ src/ccm_core.sv @@
// ----------------------------------------------------------------------------
// ccm_core
// Packet sequencer: CBC-MAC chain, CTR keystream, tag and verdict.
// ----------------------------------------------------------------------------
`include "aes128_ccm_engine_unit_assert.svh"

module ccm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_valid,
  input  logic [7:0]        in_data,
  output logic              in_pop,
  output logic              push_valid,
  output ccm_pkg::res_t     push_data,
  input  logic              out_full,
  output ccm_pkg::aes_req_t aes_req,
  input  ccm_pkg::aes_rsp_t aes_rsp
);
  import ccm_pkg::*;

  typedef enum logic [1:0] {P_START, P_AAD, P_PAY, P_TAG} phase_t;
  typedef enum logic [3:0] {
    S_IDLE, S_BEGIN_MAC, S_BEGIN_S0, S_ADV, S_ABSORB, S_BYTE, S_KS, S_EMIT, S_TAG, S_VERDICT
  } state_t;

  state_t       state_r;
  phase_t       phase_r;
  logic [63:0]  key_hi_r, key_lo_r, nonce_hi_r;
  logic [39:0]  nonce_lo_r;
  logic [15:0]  aad_len_r, pay_len_r;
  logic         dir_r;
  logic [127:0] mac_r, ks_r, buf_r, blk_r, buf_wr;
  logic [63:0]  tmask_r, rtag_r;
  logic [15:0]  ctr_r;
  logic [16:0]  pos_r;
  logic [7:0]   byte_r, ks_byte, o_byte;
  logic [2:0]   tagi_r;
  logic         second_r, ret_tag_r, start_r;
  logic [3:0]   hdr_off, off1, off2;
  logic         adv_aad, adv_pay;
  logic [127:0] hdr_blk;

  assign hdr_off = (aad_len_r >= LONG_AAD) ? 4'd6 : 4'd2;
  assign off1    = hdr_off + pos_r[3:0];
  assign off2    = pos_r[3:0];
  assign adv_aad = (phase_r == P_AAD) && (pos_r >= {1'b0, aad_len_r});
  assign adv_pay = (phase_r == P_PAY) && (pos_r >= {1'b0, pay_len_r});
  assign hdr_blk = (aad_len_r >= LONG_AAD) ? {8'hFF, 8'hFE, 16'h0, aad_len_r, 80'h0}
                                           : {aad_len_r, 112'h0};
  assign ks_byte = get_byte(ks_r, off2);
  assign o_byte  = byte_r ^ ks_byte;
  assign buf_wr  = (state_r == S_EMIT) ? set_byte(buf_r, off2, dir_r ? o_byte : byte_r)
                                       : set_byte(buf_r, off1, byte_r);

  assign in_pop  = (state_r == S_IDLE) && in_valid;
  assign aes_req = '{start: start_r, blk: blk_r, key: {key_hi_r, key_lo_r}};

  always_comb begin
    push_data = '{data: o_byte, kind: KIND_PAYLOAD, auth_ok: 1'b0, last: 1'b0};
    case (state_r)
      S_TAG: begin
        push_data = '{data: get_byte(mac_r ^ {tmask_r, 64'h0}, {1'b0, tagi_r}),
                      kind: KIND_TAG, auth_ok: 1'b0, last: (tagi_r == 3'd7)};
      end
      S_VERDICT: begin
        push_data = '{data: 8'h00, kind: KIND_VERDICT,
                      auth_ok: ((mac_r[127:64] ^ tmask_r) == rtag_r), last: 1'b1};
      end
      default: ;
    endcase
  end
  assign push_valid = !out_full &&
                      (state_r == S_EMIT || state_r == S_TAG || state_r == S_VERDICT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r   <= '0;
      key_lo_r   <= '0;
      nonce_hi_r <= '0;
      nonce_lo_r <= '0;
      aad_len_r  <= 16'd1;
      pay_len_r  <= '0;
      dir_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH:   key_hi_r   <= cfg_data;
        REG_KEY_LOW:    key_lo_r   <= cfg_data;
        REG_NONCE_HIGH: nonce_hi_r <= cfg_data;
        REG_NONCE_LOW:  nonce_lo_r <= cfg_data[39:0];
        REG_AAD_LEN:    aad_len_r  <= cfg_data[15:0];
        REG_PAY_LEN:    pay_len_r  <= cfg_data[15:0];
        REG_DIRECTION:  dir_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= P_START;
      start_r   <= 1'b0;
      pos_r     <= '0;
      ctr_r     <= 16'd1;
      tagi_r    <= '0;
      second_r  <= 1'b0;
      ret_tag_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            byte_r   <= in_data;
            second_r <= 1'b0;
            if (phase_r == P_START) begin
              start_r <= 1'b1;
              blk_r   <= {FLAGS_B0, nonce_hi_r, nonce_lo_r, pay_len_r};
              state_r <= S_BEGIN_MAC;
            end else begin
              state_r <= S_ADV;
            end
          end
        end
        S_BEGIN_MAC: begin
          if (aes_rsp.done) begin
            mac_r   <= aes_rsp.data;
            start_r <= 1'b1;
            blk_r   <= {FLAGS_CTR, nonce_hi_r, nonce_lo_r, 16'h0};
            state_r <= S_BEGIN_S0;
          end
        end
        S_BEGIN_S0: begin
          if (aes_rsp.done) begin
            tmask_r <= aes_rsp.data[127:64];
            buf_r   <= hdr_blk;
            ctr_r   <= 16'd1;
            pos_r   <= '0;
            phase_r <= P_AAD;
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          if (adv_aad) begin
            phase_r <= P_PAY;
            pos_r   <= '0;
            if (off1 != 4'd0) begin
              start_r   <= 1'b1;
              blk_r     <= mac_r ^ buf_r;
              ret_tag_r <= 1'b0;
              state_r   <= S_ABSORB;
            end
          end else if (adv_pay) begin
            pos_r   <= '0;
            tagi_r  <= '0;
            phase_r <= dir_r ? P_TAG : P_START;
            if (off2 != 4'd0) begin
              start_r   <= 1'b1;
              blk_r     <= mac_r ^ buf_r;
              ret_tag_r <= !dir_r;
              state_r   <= S_ABSORB;
            end else begin
              state_r <= dir_r ? S_ADV : S_TAG;
            end
          end else if (second_r) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_BYTE;
          end
        end
        S_ABSORB: begin
          if (aes_rsp.done) begin
            mac_r   <= aes_rsp.data;
            buf_r   <= '0;
            state_r <= ret_tag_r ? S_TAG : S_ADV;
          end
        end
        S_BYTE: begin
          case (phase_r)
            P_AAD: begin
              buf_r    <= buf_wr;
              pos_r    <= pos_r + 17'd1;
              second_r <= 1'b1;
              if (off1 == 4'd15) begin
                start_r   <= 1'b1;
                blk_r     <= mac_r ^ buf_wr;
                ret_tag_r <= 1'b0;
                state_r   <= S_ABSORB;
              end else begin
                state_r <= S_ADV;
              end
            end
            P_PAY: begin
              if (off2 == 4'd0) begin
                start_r <= 1'b1;
                blk_r   <= {FLAGS_CTR, nonce_hi_r, nonce_lo_r, ctr_r};
                ctr_r   <= ctr_r + 16'd1;
                state_r <= S_KS;
              end else begin
                state_r <= S_EMIT;
              end
            end
            P_TAG: begin
              rtag_r[63-8*pos_r[2:0] -: 8] <= byte_r;
              pos_r <= pos_r + 17'd1;
              state_r <= (pos_r[2:0] == 3'd7) ? S_VERDICT : S_IDLE;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_KS: begin
          if (aes_rsp.done) begin
            ks_r    <= aes_rsp.data;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_full) begin
            buf_r    <= buf_wr;
            pos_r    <= pos_r + 17'd1;
            second_r <= 1'b1;
            if (off2 == 4'd15) begin
              start_r   <= 1'b1;
              blk_r     <= mac_r ^ buf_wr;
              ret_tag_r <= 1'b0;
              state_r   <= S_ABSORB;
            end else begin
              state_r <= S_ADV;
            end
          end
        end
        S_TAG: begin
          if (!out_full) begin
            tagi_r <= tagi_r + 3'd1;
            if (tagi_r == 3'd7) state_r <= S_IDLE;
          end
        end
        S_VERDICT: begin
          if (!out_full) begin
            phase_r <= P_START;
            pos_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CCM_ASSERT_IMP(a_start_idle, aes_req.start, !aes_rsp.busy, "aes start while busy")
  `CCM_ASSERT_IMP(a_push_room, push_valid, !out_full, "result pushed into full queue")
  `CCM_ASSERT_IMP(a_tag_pos, phase_r == P_TAG && state_r != S_VERDICT, pos_r < 17'd8, "tag position past 8")
endmodule

@@ src/aes128_ccm_engine_unit.sv @@
// ----------------------------------------------------------------------------
// aes128_ccm_engine_unit
// AES-128 CCM (8-byte tag, 2-byte length) byte-stream engine.
// ----------------------------------------------------------------------------
// Usage:
//  - program key, nonce, lengths and direction through cfg_we/cfg_index/cfg_data
//    while the engine is idle
//  - stream one word per packet byte on in_*: aad, then payload, then the
//    8 received tag bytes when decrypting
//  - out_* carries payload bytes (kind 0), tag bytes (kind 1) or the verdict
//    (kind 2); out_last marks the final word of a packet
// AES use and stalls:
//  - the first byte of a packet costs two AES passes (B0 and A0)
//  - every AES pass runs through the single iterative round unit; every
//    16 payload bytes need two passes (keystream and MAC), every 16 aad
//    bytes one
//  - small input and output queues let the sides stall independently; a
//    stalled out_* word holds until taken, and the engine waits when full
// Reset: synchronous rst_n clears registers to their defaults and starts a
// new packet on the next input word.
// ----------------------------------------------------------------------------
module aes128_ccm_engine_unit #(
  parameter int IN_DEPTH  = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_auth_ok,
  output logic        out_last
);
  import ccm_pkg::*;

  logic     in_full, q_valid, q_pop, push_valid, out_full;
  logic [7:0] q_data;
  res_t     push_data, head;
  aes_req_t aes_req;
  aes_rsp_t aes_rsp;

  assign in_stall = in_full;

  ccm_fifo #(.W(8), .D(IN_DEPTH)) u_in_q (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_data(in_byte), .wr_full(in_full),
    .rd_valid(q_valid), .rd_data(q_data), .rd_pop(q_pop)
  );

  ccm_aes u_aes (
    .clk(clk), .rst_n(rst_n), .req(aes_req), .rsp(aes_rsp)
  );

  ccm_core u_core (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(q_valid), .in_data(q_data), .in_pop(q_pop),
    .push_valid(push_valid), .push_data(push_data), .out_full(out_full),
    .aes_req(aes_req), .aes_rsp(aes_rsp)
  );

  ccm_fifo #(.W($bits(res_t)), .D(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(push_valid), .wr_data(push_data), .wr_full(out_full),
    .rd_valid(out_valid), .rd_data(head), .rd_pop(!out_stall)
  );

  assign out_byte    = head.data;
  assign out_kind    = head.kind;
  assign out_auth_ok = head.auth_ok;
  assign out_last    = head.last;
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AES-128 CCM byte engine (8-byte tag, L=2).
// Directed packets cover the reset setup, the empty packet, empty and long
// AAD, and good and bad tags. Random packets follow. Every word is checked
// against a byte-level CCM predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ccm_pkg::*;

  typedef logic [7:0] b8_t;
  localparam int LIMIT = 4000000;
  localparam int DRAIN = 100;
  localparam int RANDOM_ITEMS = 340;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_auth_ok;
  logic        out_last;

  aes128_ccm_engine_unit uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_byte,
    .out_valid, .out_stall, .out_byte, .out_kind, .out_auth_ok, .out_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [63:0] key_hi, key_lo, nonce_hi;
  logic [39:0] nonce_lo;
  logic [15:0] aad_len, pay_len;
  logic        decrypt;
  b8_t         rkeys [176];
  b8_t         mac [16];
  b8_t         kstream [16];
  b8_t         blkbuf [16];
  b8_t         mask [8];
  b8_t         rx_tag [8];
  logic [15:0] ctr;
  int          pos;
  int          phase;

  res_t        expected_words [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_words = 0;
  int          n_packets = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  function automatic b8_t dbl(b8_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void expand_keys();
    b8_t w [4];
    b8_t rc, first;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rkeys[i] = key_hi[63-8*i -: 8];
      rkeys[8+i] = key_lo[63-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rkeys[i-4+j];
      if (i % 16 == 0) begin
        first = w[0];
        w[0] = SBOX[w[1]] ^ rc;
        w[1] = SBOX[w[2]];
        w[2] = SBOX[w[3]];
        w[3] = SBOX[first];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rkeys[i+j] = rkeys[i-16+j] ^ w[j];
    end
  endfunction

  function automatic void aes_encrypt(input b8_t din [16], output b8_t dout [16]);
    b8_t st [16];
    b8_t sh [16];
    b8_t a0, a1, a2, a3, all;
    for (int i = 0; i < 16; i++) st[i] = din[i] ^ rkeys[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) sh[4*c+i] = SBOX[st[4*((c+i)%4)+i]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          sh[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
          sh[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
          sh[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
          sh[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rkeys[16*r+i];
    end
    dout = st;
  endfunction

  function automatic void nonce_blk(output b8_t blk [16], input b8_t flags,
                                    input logic [15:0] cnt);
    blk[0] = flags;
    for (int i = 0; i < 8; i++) blk[1+i] = nonce_hi[63-8*i -: 8];
    for (int i = 0; i < 5; i++) blk[9+i] = nonce_lo[39-8*i -: 8];
    blk[14] = cnt[15:8];
    blk[15] = cnt[7:0];
  endfunction

  function automatic int hdr_size();
    return (aad_len >= LONG_AAD) ? 6 : 2;
  endfunction

  function automatic void absorb();
    for (int i = 0; i < 16; i++) mac[i] ^= blkbuf[i];
    aes_encrypt(mac, mac);
    for (int i = 0; i < 16; i++) blkbuf[i] = '0;
  endfunction

  function automatic void push_word(b8_t d, logic [1:0] k, logic ok, logic lst);
    res_t r;
    r.data = d; r.kind = k; r.auth_ok = ok; r.last = lst;
    expected_words.push_back(r);
  endfunction

  function automatic void begin_packet();
    b8_t blk [16];
    b8_t s0 [16];
    nonce_blk(blk, FLAGS_B0, pay_len);
    aes_encrypt(blk, mac);
    nonce_blk(blk, FLAGS_CTR, 16'd0);
    aes_encrypt(blk, s0);
    for (int i = 0; i < 8; i++) mask[i] = s0[i];
    for (int i = 0; i < 16; i++) blkbuf[i] = '0;
    if (aad_len >= LONG_AAD) begin
      blkbuf[0] = 8'hFF; blkbuf[1] = 8'hFE;
      blkbuf[4] = aad_len[15:8]; blkbuf[5] = aad_len[7:0];
    end else begin
      blkbuf[0] = aad_len[15:8]; blkbuf[1] = aad_len[7:0];
    end
    ctr = 16'd1;
    pos = 0;
    phase = 1;
  endfunction

  // move past finished sections, emitting the tag when encrypting
  function automatic void close_sections();
    if (phase == 1 && pos >= aad_len) begin
      if ((hdr_size() + pos) % 16 != 0) absorb();
      phase = 2;
      pos = 0;
    end
    if (phase == 2 && pos >= pay_len) begin
      if (pos % 16 != 0) absorb();
      pos = 0;
      if (!decrypt) begin
        for (int i = 0; i < 8; i++) push_word(mac[i] ^ mask[i], KIND_TAG, 1'b0, i == 7);
        phase = 0;
      end else begin
        phase = 3;
      end
    end
  endfunction

  function automatic void ccm_step(b8_t b);
    int off;
    bit ok;
    b8_t blk [16];
    b8_t o;
    if (phase == 0) begin_packet();
    close_sections();
    if (phase == 0) return;
    if (phase == 1) begin
      off = (hdr_size() + pos) % 16;
      blkbuf[off] = b;
      pos++;
      if (off == 15) absorb();
    end else if (phase == 2) begin
      off = pos % 16;
      if (off == 0) begin
        nonce_blk(blk, FLAGS_CTR, ctr);
        aes_encrypt(blk, kstream);
        ctr = ctr + 16'd1;
      end
      o = b ^ kstream[off];
      blkbuf[off] = decrypt ? o : b;
      push_word(o, KIND_PAYLOAD, 1'b0, 1'b0);
      pos++;
      if (off == 15) absorb();
    end else begin
      rx_tag[pos % 8] = b;
      pos++;
      if (pos >= 8) begin
        ok = 1'b1;
        for (int i = 0; i < 8; i++) if ((mac[i] ^ mask[i]) != rx_tag[i]) ok = 1'b0;
        push_word(8'h00, KIND_VERDICT, ok, 1'b1);
        phase = 0;
        pos = 0;
      end
      return;
    end
    close_sections();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s at word %0d: got %0h expected %0h", what, n_words, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_byte, 0);
      end else begin
        e = expected_words.pop_front();
        if (out_byte !== e.data) report_mismatch("out_byte", out_byte, e.data);
        if (out_kind !== e.kind) report_mismatch("out_kind", out_kind, e.kind);
        if (out_auth_ok !== e.auth_ok) report_mismatch("out_auth_ok", out_auth_ok, e.auth_ok);
        if (out_last !== e.last) report_mismatch("out_last", out_last, e.last);
      end
      n_words++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               expected_words.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random hold-off before each word
  initial begin
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      @(negedge clk);
    end
  end

  task automatic send_word(b8_t b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    ccm_step(b);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_KEY_HIGH:   begin key_hi = val; expand_keys(); end
      REG_KEY_LOW:    begin key_lo = val; expand_keys(); end
      REG_NONCE_HIGH: nonce_hi = val;
      REG_NONCE_LOW:  nonce_lo = val[39:0];
      REG_AAD_LEN:    aad_len = val[15:0];
      REG_PAY_LEN:    pay_len = val[15:0];
      REG_DIRECTION:  decrypt = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [63:0] kh, logic [63:0] kl, logic [63:0] nh,
                            logic [63:0] nl, int aad, int pay, bit dir);
    wait_idle();
    write_reg(REG_KEY_HIGH, kh);
    write_reg(REG_KEY_LOW, kl);
    write_reg(REG_NONCE_HIGH, nh);
    write_reg(REG_NONCE_LOW, nl);
    write_reg(REG_AAD_LEN, 64'(aad));
    write_reg(REG_PAY_LEN, 64'(pay));
    write_reg(REG_DIRECTION, 64'(dir));
  endtask

  // fill < 0 gives random bytes; bad flips one tag bit when decrypting
  task automatic run_packet(int fill, bit bad);
    b8_t b;
    do begin
      if (phase == 3) begin
        b = mac[pos % 8] ^ mask[pos % 8];
        if (bad && pos == 3) b ^= 8'h10;
      end else begin
        b = (fill < 0) ? b8_t'($urandom) : b8_t'(fill);
      end
      send_word(b);
    end while (phase != 0);
    n_packets++;
  endtask

  typedef struct {
    bit ones;
    bit dir;
    int aad;
    int pay;
    int fill;
    bit bad;
  } pkt_row_t;

  pkt_row_t directed [5] = '{
    '{1'b0, 1'b0, 1, 0, 8'h00, 1'b0},  // reset settings
    '{1'b1, 1'b0, 0, 0, 8'hFF, 1'b0},  // empty packet, byte ignored
    '{1'b1, 1'b0, 0, 3, 8'hFF, 1'b0},  // empty aad
    '{1'b1, 1'b1, 2, 2, 8'h00, 1'b0},  // decrypt, good tag
    '{1'b0, 1'b1, 1, 1, 8'hFF, 1'b1}   // decrypt, bad tag
  };

  initial begin
    logic [63:0] k0, k1, n0, n1;
    int aad, pay, npk;
    bit dir;
    key_hi = '0; key_lo = '0; nonce_hi = '0; nonce_lo = '0;
    aad_len = 16'd1; pay_len = '0; decrypt = 1'b0;
    for (int i = 0; i < 16; i++) begin
      mac[i] = '0; kstream[i] = '0; blkbuf[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      mask[i] = '0; rx_tag[i] = '0;
    end
    ctr = 16'd1; pos = 0; phase = 0;
    expand_keys();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: first row runs on the reset settings
    foreach (directed[r]) begin
      if (r > 0) begin
        k0 = directed[r].ones ? '1 : '0;
        set_config(k0, k0, k0, k0, directed[r].aad, directed[r].pay, directed[r].dir);
      end
      run_packet(directed[r].fill, directed[r].bad);
    end

    // six-byte length header, then the aad length is cut short mid-packet
    quiet = 1'b1;
    set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, 16'hFFFF, 2, 1'b0);
    repeat (20) send_word(b8_t'($urandom));
    wait_idle();
    write_reg(REG_AAD_LEN, 64'd20);
    run_packet(-1, 1'b0);
    quiet = 1'b0;

    while (n_items < RANDOM_ITEMS) begin
      k0 = {$urandom, $urandom}; k1 = {$urandom, $urandom};
      n0 = {$urandom, $urandom}; n1 = {$urandom, $urandom};
      aad = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      pay = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
      dir = $urandom_range(0, 1);
      quiet = ($urandom_range(0, 4) == 0);
      set_config(k0, k1, n0, n1, aad, pay, dir);
      npk = $urandom_range(1, 3);
      repeat (npk) run_packet(-1, $urandom_range(0, 3) == 0);
    end
    quiet = 1'b0;

    wait_idle();
    $display("covered %0d packets, %0d input words, %0d result words in %0d cycles",
             n_packets, n_items, n_words, cycles);
    $display("encrypt and decrypt, empty, short and long aad, good and bad tags");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
